[rtl/lbr_pkg.sv]
// ============================================================================
// lbr_pkg - shared types for the Bresenham line raster unit
// Request operation codes used by the raster core and its testbench.
// ============================================================================
package lbr_pkg;

  // Request operation: load a new line, or emit the next pixel of it
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } lbr_op_t;

endpackage : lbr_pkg

[rtl/line_bresenham_raster_unit.sv]
// ============================================================================
// line_bresenham_raster_unit - integer Bresenham line rasterizer, all octants
// Loads a line between two signed endpoints, then emits one pixel per step.
// ============================================================================
//
// A load request sets up a line between (start_x, start_y) and (end_x, end_y)
// and returns nothing; it replaces any line still in progress. Each step
// request returns one pixel of the line, in ascending order along the major
// axis (so the walk may begin at either endpoint), with last_pixel set on the
// final one. A step with no line in progress returns nothing. Equal endpoints
// give a single pixel flagged last. The unit takes one request per clock
// while the input does not stall: a request is captured in an input
// register, then one pass of combinational logic (octant reduction on load,
// or the decision update and octant mapping on step) writes the line state
// and the result register, so a pixel is presented from the result register
// once its step request has left the input register. The result register
// parts the two channels: a new request is taken while a pixel waits to be
// read, and the input stalls only when a captured step has a pixel to write
// and the result register is full and stalled.
//
module line_bresenham_raster_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  // Pixel channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_last_pixel
);

  // Reduced coordinates need one extra bit (negating the most negative
  // value); the decision variable ranges over about +/- 2^(COORD_BITS+1).
  localparam int W = COORD_BITS + 1;
  localparam int D = COORD_BITS + 3;

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                         s1_valid_r;
  lbr_pkg::lbr_op_t             s1_op_r;
  logic signed [COORD_BITS-1:0] s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;

  // Line state
  logic signed [W-1:0]          walk_x_r, walk_y_r, stop_x_r;
  logic signed [D-1:0]          decision_r;
  logic [COORD_BITS-1:0]        delta_major_r, delta_minor_r;
  logic                         axes_swapped_r, y_negated_r, line_active_r;

  // Result register
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_pixel_x_r, out_pixel_y_r;
  logic                         out_last_pixel_r;

  logic in_take;
  logic s1_emit;
  logic s1_adv;

  // A captured step with a live line writes a pixel; everything else
  // retires without touching the result register.
  assign s1_emit  = (s1_op_r == lbr_pkg::OP_STEP) && line_active_r;
  assign s1_adv   = s1_valid_r && (!s1_emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Load path: reduce the line to the first octant
  // --------------------------------------------------------------------------
  logic signed [W-1:0]   ax, ay, bx, by;
  logic signed [W-1:0]   dx, dy, adx_w, ady_w;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  ld_neg, ld_swap, ld_order;
  logic signed [W-1:0]   nay, nby;
  logic signed [W-1:0]   ra_x, ra_y, rb_x, rb_y;
  logic signed [W-1:0]   ld_walk_x, ld_walk_y, ld_stop_x;
  logic [COORD_BITS-1:0] ld_dmaj, ld_dmin;
  logic signed [D-1:0]   ld_decision;

  always_comb begin
    ax = {s1_sx_r[COORD_BITS-1], s1_sx_r};
    ay = {s1_sy_r[COORD_BITS-1], s1_sy_r};
    bx = {s1_ex_r[COORD_BITS-1], s1_ex_r};
    by = {s1_ey_r[COORD_BITS-1], s1_ey_r};
    dx = bx - ax;
    dy = by - ay;
    adx_w = dx[W-1] ? -dx : dx;
    ady_w = dy[W-1] ? -dy : dy;
    adx = adx_w[COORD_BITS-1:0];
    ady = ady_w[COORD_BITS-1:0];

    // Negative slope: mirror y so both deltas share a sign
    ld_neg = (dx[W-1] && !dy[W-1] && (dy != '0)) ||
             (dy[W-1] && !dx[W-1] && (dx != '0));
    nay = ld_neg ? -ay : ay;
    nby = ld_neg ? -by : by;

    // Steep line: walk along y instead
    ld_swap = adx < ady;
    ra_x = ld_swap ? nay : ax;
    ra_y = ld_swap ? ax  : nay;
    rb_x = ld_swap ? nby : bx;
    rb_y = ld_swap ? bx  : nby;

    // Walk from the endpoint with the smaller reduced x
    ld_order  = ra_x > rb_x;
    ld_walk_x = ld_order ? rb_x : ra_x;
    ld_walk_y = ld_order ? rb_y : ra_y;
    ld_stop_x = ld_order ? ra_x : rb_x;

    // Reduced deltas are the larger and smaller absolute deltas
    ld_dmaj = ld_swap ? ady : adx;
    ld_dmin = ld_swap ? adx : ady;
    ld_decision = D'({2'b00, ld_dmin, 1'b0}) - D'({3'b000, ld_dmaj});
  end

  // --------------------------------------------------------------------------
  // Step path: emit the current pixel and advance the decision variable
  // --------------------------------------------------------------------------
  logic                  st_last;
  logic                  st_ne;
  logic signed [W-1:0]   st_px, st_py, st_py_n;
  logic signed [D-1:0]   st_inc;

  always_comb begin
    st_last = walk_x_r >= stop_x_r;
    st_ne   = !decision_r[D-1] && (decision_r != '0);
    // North-east step shrinks the error, east step grows it
    st_inc  = st_ne ? (D'({2'b00, delta_minor_r, 1'b0}) - D'({2'b00, delta_major_r, 1'b0}))
                    : D'({2'b00, delta_minor_r, 1'b0});
    // Map back to the true octant
    st_px   = axes_swapped_r ? walk_y_r : walk_x_r;
    st_py   = axes_swapped_r ? walk_x_r : walk_y_r;
    st_py_n = y_negated_r ? -st_py : st_py;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      line_active_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv && s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_op_r == lbr_pkg::OP_LOAD) begin
          line_active_r <= 1'b1;
        end else if (line_active_r && st_last) begin
          line_active_r <= 1'b0;
        end
      end
    end
  end

  // Captured request payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= lbr_pkg::lbr_op_t'(in_operation);
      s1_sx_r <= in_start_x;
      s1_sy_r <= in_start_y;
      s1_ex_r <= in_end_x;
      s1_ey_r <= in_end_y;
    end
  end

  // Line state: replace on load, advance on an emitting step
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_op_r == lbr_pkg::OP_LOAD) begin
        walk_x_r       <= ld_walk_x;
        walk_y_r       <= ld_walk_y;
        stop_x_r       <= ld_stop_x;
        decision_r     <= ld_decision;
        delta_major_r  <= ld_dmaj;
        delta_minor_r  <= ld_dmin;
        axes_swapped_r <= ld_swap;
        y_negated_r    <= ld_neg;
      end else if (line_active_r) begin
        walk_x_r   <= walk_x_r + W'(1);
        decision_r <= decision_r + st_inc;
        if (st_ne) begin
          walk_y_r <= walk_y_r + W'(1);
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_pixel_x_r    <= st_px[COORD_BITS-1:0];
      out_pixel_y_r    <= st_py_n[COORD_BITS-1:0];
      out_last_pixel_r <= st_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_pixel_x_r;
  assign out_pixel_y    = out_pixel_y_r;
  assign out_last_pixel = out_last_pixel_r;

endmodule : line_bresenham_raster_unit

[rtl/lbr_checker.sv]
// ============================================================================
// lbr_checker - port-level checks for the Bresenham line raster unit
// Watches the request and pixel channels of the top level through a bind.
// ============================================================================
module lbr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_operation,
  input logic signed [COORD_BITS-1:0] in_start_x,
  input logic signed [COORD_BITS-1:0] in_start_y,
  input logic signed [COORD_BITS-1:0] in_end_x,
  input logic signed [COORD_BITS-1:0] in_end_y,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_pixel_x,
  input logic signed [COORD_BITS-1:0] out_pixel_y,
  input logic                         out_last_pixel
);

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_operation) &&
                             $stable(in_start_x) && $stable(in_start_y) &&
                             $stable(in_end_x) && $stable(in_end_y))
    else $error("stalled request changed");

  // Hold a stalled pixel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("pixel dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pixel_x) && $stable(out_pixel_y) &&
                               $stable(out_last_pixel))
    else $error("stalled pixel changed");

  // Reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel presented right after reset");

  // Back-pressure on requests only comes from a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with room for a pixel");

endmodule : lbr_checker

bind line_bresenham_raster_unit lbr_checker #(
  .COORD_BITS(COORD_BITS)
) u_lbr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .in_start_x     (in_start_x),
  .in_start_y     (in_start_y),
  .in_end_x       (in_end_x),
  .in_end_y       (in_end_y),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_last_pixel (out_last_pixel)
);

[dv/line_bresenham_raster_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_bresenham_raster_unit_tb - self-checking bench for the line raster unit
// Drives load and step requests, predicts every pixel in a scoreboard class
// and compares each returned pixel field by field under varied handshaking.
// ----------------------------------------------------------------------------
module line_bresenham_raster_unit_tb;

  localparam int CB         = 12;
  localparam int CYCLE_CAP  = 600000;   // far above the slowest correct run
  localparam int TAIL_WAIT  = 12;       // covers the input and result registers
  localparam int PHASE_REQS = 225;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the line state, queues the pixels each step request
  // must produce, and checks returned pixels against the oldest one queued.
  // --------------------------------------------------------------------------
  class pixel_tracker;
    logic signed [CB:0]   walk_x, walk_y, stop_x;
    logic signed [CB+2:0] decision;
    logic [CB-1:0]        delta_major, delta_minor;
    bit                   axes_swapped, y_negated, line_active;
    pixel_t               pending_pixels[$];
    int                   mismatches;
    int                   pixels_checked;
    int                   loads_seen;

    function int iabs(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Fold the line into the first octant on load; emit one pixel per step.
    function void note_request(lbr_pkg::lbr_op_t op, coord_t sx, coord_t sy,
                               coord_t ex, coord_t ey);
      int     ax, ay, bx, by, dx, dy, t, px, py, d;
      bit     last_flag;
      pixel_t p;
      if (op == lbr_pkg::OP_LOAD) begin
        loads_seen++;
        ax = sx; ay = sy; bx = ex; by = ey;
        dx = bx - ax;
        dy = by - ay;
        y_negated = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
        if (y_negated) begin
          ay = -ay;
          by = -by;
        end
        axes_swapped = iabs(dx) < iabs(dy);
        if (axes_swapped) begin
          t = ax; ax = ay; ay = t;
          t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
          t = ax; ax = bx; bx = t;
          t = ay; ay = by; by = t;
        end
        walk_x      = 13'(ax);
        walk_y      = 13'(ay);
        stop_x      = 13'(bx);
        delta_major = 12'(bx - ax);
        delta_minor = 12'(by - ay);
        decision    = 15'(2 * (by - ay) - (bx - ax));
        line_active = 1'b1;
        return;
      end
      // step with no line in progress: nothing comes back
      if (!line_active) return;
      px        = int'(walk_x);
      py        = int'(walk_y);
      last_flag = (walk_x >= stop_x);
      if (axes_swapped) begin
        t = px; px = py; py = t;
      end
      if (y_negated) py = -py;
      p.x    = coord_t'(px);
      p.y    = coord_t'(py);
      p.last = last_flag;
      pending_pixels = {pending_pixels, p};
      // advance the walk: north-east only when the decision is strictly positive
      d = int'(decision);
      if (decision > 0) begin
        d += 2 * (int'(delta_minor) - int'(delta_major));
        walk_y = walk_y + 13'sd1;
      end else begin
        d += 2 * int'(delta_minor);
      end
      decision = 15'(d);
      walk_x   = walk_x + 13'sd1;
      if (last_flag) line_active = 1'b0;
    endfunction

    function void check_pixel(coord_t x, coord_t y, logic last);
      pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel: x=%0d y=%0d last=%0b", x, y, last);
        mismatches++;
        return;
      end
      exp_px = pending_pixels[0];
      pending_pixels.delete(0);
      pixels_checked++;
      if (x !== exp_px.x) begin
        $error("pixel_x mismatch: expected %0d, got %0d", exp_px.x, x);
        mismatches++;
      end
      if (y !== exp_px.y) begin
        $error("pixel_y mismatch: expected %0d, got %0d", exp_px.y, y);
        mismatches++;
      end
      if (last !== exp_px.last) begin
        $error("last_pixel mismatch: expected %0b, got %0b", exp_px.last, last);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid, in_stall, in_operation;
  coord_t in_start_x, in_start_y, in_end_x, in_end_y;
  logic   out_valid, out_stall, out_last_pixel;
  coord_t out_pixel_x, out_pixel_y;

  always #2 clk = ~clk;

  line_bresenham_raster_unit #(.COORD_BITS(CB)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  pixel_tracker tracker;
  int send_idle_pct  = 0;   // chance per cycle that the request side idles
  int recv_stall_pct = 0;   // chance per cycle that the pixel side stalls
  int hold_left      = 0;   // cycles of forced pixel stall still to go
  int cycle_count    = 0;
  int requests_sent  = 0;

  // --------------------------------------------------------------------------
  // Pixel side: drive stall at the falling edge, check at the rising edge.
  // A pending hold overrides the random stall so the unit backs up fully.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
  end

  // Watchdog: end the run if the unit hangs.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, tracker.pending_pixels.size());
      $display("line_bresenham_raster_unit_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers
  // --------------------------------------------------------------------------
  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(4095));
  endfunction

  // Pick a point within span of base, clamped to the coordinate range.
  function automatic coord_t near_coord(coord_t base, int span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - span;
    if (v > 2047)  v = 2047;
    if (v < -2048) v = -2048;
    return coord_t'(v);
  endfunction

  // Enter at a falling edge; leave at the falling edge after acceptance.
  // Valid stays high between back-to-back requests.
  task automatic send_req(lbr_pkg::lbr_op_t op, coord_t sx, coord_t sy,
                          coord_t ex, coord_t ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_start_x   = sx;
    in_start_y   = sy;
    in_end_x     = ex;
    in_end_y     = ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(op, sx, sy, ex, ey);
    requests_sent++;
    @(negedge clk);
  endtask

  // Step with random don't-care endpoint fields.
  task automatic send_step();
    send_req(lbr_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic send_steps(int n);
    for (int i = 0; i < n; i++) send_step();
  endtask

  // Hold off new requests until every predicted pixel has come back.
  task automatic drain_pixels();
    in_valid = 1'b0;
    while (tracker.pending_pixels.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed lines walked to the end, sometimes cut short by a
  // reload, with a few stray steps and fully random requests as noise.
  task automatic run_phase(int n_reqs, int idle_pct, int stall_pct);
    int     sent, len, pick;
    coord_t sx, sy, ex, ey;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    while (sent < n_reqs) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        sx = rand_coord();
        sy = rand_coord();
        ex = near_coord(sx, ($urandom_range(9) == 0) ? 64 : 10);
        ey = near_coord(sy, ($urandom_range(9) == 0) ? 64 : 10);
        if ($urandom_range(15) == 0) begin
          ex = sx;
          ey = sy;
        end
        send_req(lbr_pkg::OP_LOAD, sx, sy, ex, ey);
        len = tracker.iabs(int'(ex) - int'(sx));
        if (tracker.iabs(int'(ey) - int'(sy)) > len) len = tracker.iabs(int'(ey) - int'(sy));
        len = len + 1;
        if ($urandom_range(9) == 0) len = $urandom_range(len);
        send_steps(len);
        sent = sent + 1 + len;
        // an extra step returns nothing once the line has finished
        if ($urandom_range(7) == 0) begin
          send_step();
          sent++;
        end
      end else begin
        send_req(lbr_pkg::lbr_op_t'($urandom_range(1)), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
        sent++;
      end
    end
    drain_pixels();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker      = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = lbr_pkg::OP_STEP;
    in_start_x   = '0;
    in_start_y   = '0;
    in_end_x     = '0;
    in_end_y     = '0;
    out_stall    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle step, degenerate line, extreme diagonals, steep lines,
    // a decision tie, and a reload that cuts a line short.
    send_step();
    send_req(lbr_pkg::OP_LOAD, 12'sd5, -12'sd3, 12'sd5, -12'sd3);
    send_steps(2);
    send_req(lbr_pkg::OP_LOAD, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
    send_steps(2);
    send_req(lbr_pkg::OP_LOAD, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
    send_steps(2);
    send_req(lbr_pkg::OP_LOAD, 12'sd0, -12'sd2048, 12'sd1, 12'sd2047);
    send_steps(2);
    send_req(lbr_pkg::OP_LOAD, 12'sd0, 12'sd0, 12'sd2, 12'sd1);
    send_steps(3);
    send_req(lbr_pkg::OP_LOAD, -12'sd1, -12'sd1, -12'sd4, 12'sd5);
    send_steps(2);
    send_req(lbr_pkg::OP_LOAD, 12'sd0, 12'sd0, -12'sd1, 12'sd0);
    send_steps(3);
    drain_pixels();

    // Random phases; a long pixel hold backs the unit up in two of them.
    hold_left = 200;
    run_phase(PHASE_REQS, 0, 0);
    run_phase(PHASE_REQS, 55, 0);
    hold_left = 150;
    run_phase(PHASE_REQS, 0, 55);
    run_phase(PHASE_REQS, 30, 30);

    // Catch any stray pixel that shows up after the last expected one.
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d requests (%0d loads) sent, %0d pixels checked", requests_sent,
             tracker.loads_seen, tracker.pixels_checked);
    $display("covered free flow, request gaps, pixel stalls, both, and long holds");
    if (tracker.mismatches == 0) begin
      $display("line_bresenham_raster_unit_tb: PASS");
    end else begin
      $display("line_bresenham_raster_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lbr_pkg.sv
rtl/line_bresenham_raster_unit.sv
rtl/lbr_checker.sv
dv/line_bresenham_raster_unit_tb.sv
